// ===== rtl/sist_pkg.sv =====
// Shared types and constants for the source address seen table.
package sist_pkg;

  localparam logic [1:0] OUT_IGNORED  = 2'd0;
  localparam logic [1:0] OUT_KNOWN    = 2'd1;
  localparam logic [1:0] OUT_INSERTED = 2'd2;
  localparam logic [1:0] OUT_FULL     = 2'd3;

  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_IPV6 = 16'h86dd;
  localparam logic [7:0]  VER_IPV4  = 8'h45;
  localparam logic [7:0]  VER_IPV6  = 8'h60;
  localparam logic [11:0] VLAN_MASK = 12'hfff;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture a new item
    logic hstep;    // add one byte lane pair to the hash sum
    logic quo;      // register the hash quotient
    logic home;     // set probe pointer to the home slot
    logic clr_step; // write zero at the clear pointer
    logic rd;       // mark the table read at probe pointer
    logic adv;      // advance probe pointer
    logic wr;       // write the address at probe pointer
  } sist_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic active;   // item is IPv4 or IPv6
    logic hlast;    // last hash step
    logic match;
    logic empty;
    logic last;
  } sist_sts_t;

  function automatic logic [7:0] v6_weight(input logic [3:0] k);
    logic [7:0] w;
    case (k)
      4'd0: w = 8'd1;   4'd1: w = 8'd2;   4'd2: w = 8'd3;   4'd3: w = 8'd5;
      4'd4: w = 8'd7;   4'd5: w = 8'd11;  4'd6: w = 8'd13;  4'd7: w = 8'd17;
      4'd8: w = 8'd19;  4'd9: w = 8'd23;  4'd10: w = 8'd29; 4'd11: w = 8'd31;
      4'd12: w = 8'd37; 4'd13: w = 8'd41; 4'd14: w = 8'd43; default: w = 8'd47;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/source_ip_seen_table.sv =====
// Top level of the source address seen table: controller plus datapath.
//
// Input channel: in_valid/in_stall carry one frame header item (EtherType,
// tag, version byte, 128-bit source). Output channel: out_valid/out_stall
// carry one result item per input item (outcome, is_v6, slot, vlan_id).
// Each item is hashed to a home slot (eight sum steps, each of two bytes
// for IPv6 and one or none for IPv4, then a reciprocal multiply and a
// subtract for the remainder), and the IPv4 or IPv6 table is probed
// linearly, each slot with a RAM read, then a compare, over the single RAM
// port of each table. One item is in flight at a time; the next item can be
// taken in the cycle after the result moves into the output register.
// Reset: the tables are swept to zero, one slot per cycle; in_stall stays
// high after reset until the sweep is done.
// When the receiver stalls, the result register holds its item and the
// block waits with its finished result before taking a new item.
module source_ip_seen_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] outer_type,
  input  logic [15:0] tag_control,
  input  logic [15:0] inner_type,
  input  logic [7:0]  version_byte,
  input  logic [63:0] src_high,
  input  logic [63:0] src_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  outcome,
  output logic        is_v6,
  output logic [7:0]  slot,
  output logic [11:0] vlan_id
);
  import sist_pkg::*;

  sist_cmd_t   cmd;
  sist_sts_t   sts;
  logic        dp_v6;
  logic [7:0]  dp_slot;
  logic [11:0] dp_vlan;

  // Hash, probe pointer and tables
  sist_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk, .rst, .cmd, .sts,
    .outer_type, .tag_control, .inner_type, .version_byte, .src_high, .src_low,
    .is_v6(dp_v6), .slot_q(dp_slot), .vlan_id_q(dp_vlan)
  );

  // Sequencing and the output register
  sist_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .outcome, .res_v6(is_v6), .slot, .vlan_id,
    .dp_v6, .dp_slot, .dp_vlan, .cmd, .sts
  );
endmodule

// ===== rtl/sist_ram.sv =====
// Generic single-port RAM with registered read.
module sist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/sist_datapath.sv =====
// Datapath: frame decode, hash, probe pointer and the two address tables.
module sist_datapath #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  sist_pkg::sist_cmd_t cmd,
  output sist_pkg::sist_sts_t sts,
  input  logic [15:0]         outer_type,
  input  logic [15:0]         tag_control,
  input  logic [15:0]         inner_type,
  input  logic [7:0]          version_byte,
  input  logic [63:0]         src_high,
  input  logic [63:0]         src_low,
  output logic                is_v6,
  output logic [7:0]          slot_q,
  output logic [11:0]         vlan_id_q
);
  import sist_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  // Hash sum stays below 2^17: 255 times the sum of the sixteen weights
  localparam int HW = 17;
  // Quotient by reciprocal multiply, exact for every sum below 2^HW
  localparam int RSH = HW + AW;
  localparam int RW  = HW + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << RSH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);

  logic [15:0]      etype;
  logic             has_tag, is4_in, is6_in;

  logic             v6;
  logic             act;
  logic [63:0]      hi, lo, hi_sh, lo_sh;
  logic [2:0]       hk;
  logic [HW-1:0]    hsum, quo, rem;
  logic [15:0]      term_hi, term_lo;
  logic [HW+RW-1:0] prod;
  logic [AW-1:0]    home;
  logic [AW-1:0]    ptr, last, cptr;
  logic             clr_done;

  logic [31:0]      v4_rd;
  logic [63:0]      v6h_rd, v6l_rd;
  logic             clr;
  logic [AW-1:0]    ram_addr;

  assign has_tag = (outer_type == TYPE_VLAN);
  assign etype   = has_tag ? inner_type : outer_type;
  assign is4_in  = (etype == TYPE_IPV4) && (version_byte == VER_IPV4);
  assign is6_in  = !is4_in && (etype == TYPE_IPV6) && (version_byte == VER_IPV6);

  // One byte of each half per step; IPv4 uses only the top four bytes.
  assign term_hi = (v6 || !hk[2]) ? 16'(hi_sh[63:56]) * 16'(v6_weight({1'b0, hk})) : '0;
  assign term_lo = v6 ? 16'(lo_sh[63:56]) * 16'(v6_weight({1'b1, hk})) : '0;

  assign prod = (HW+RW)'(hsum) * (HW+RW)'(RECIP);
  assign rem  = hsum - (quo * HW'(TABLE_DEPTH));
  assign home = rem[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cptr     <= '0;
      clr_done <= 1'b0;
      act      <= 1'b0;
      v6       <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        cptr <= (cptr == AW'(TABLE_DEPTH - 1)) ? '0 : cptr + 1'b1;
        if (cptr == AW'(TABLE_DEPTH - 1)) begin
          clr_done <= 1'b1;
        end
      end
      if (cmd.load) begin
        act <= is4_in || is6_in;
        v6  <= is6_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hi        <= src_high;
      lo        <= src_low;
      hi_sh     <= src_high;
      lo_sh     <= src_low;
      hsum      <= '0;
      hk        <= '0;
      vlan_id_q <= has_tag ? (tag_control[11:0] & VLAN_MASK) : '0;
    end else if (cmd.hstep) begin
      hi_sh <= {hi_sh[55:0], 8'd0};
      lo_sh <= {lo_sh[55:0], 8'd0};
      hsum  <= hsum + HW'(term_hi) + HW'(term_lo);
      hk    <= hk + 3'd1;
    end
    if (cmd.quo) begin
      quo <= HW'(prod >> RSH);
    end
    if (cmd.home) begin
      ptr  <= home;
      last <= (home == '0) ? AW'(TABLE_DEPTH - 1) : home - 1'b1;
    end else if (cmd.adv) begin
      ptr <= (ptr == AW'(TABLE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    end
  end

  assign clr      = cmd.clr_step;
  assign ram_addr = clr ? cptr : ptr;

  sist_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_v4 (
    .clk, .we(clr || (cmd.wr && !v6)), .addr(ram_addr),
    .wdata(clr ? 32'd0 : hi[63:32]), .rdata(v4_rd)
  );
  sist_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_v6h (
    .clk, .we(clr || (cmd.wr && v6)), .addr(ram_addr),
    .wdata(clr ? 64'd0 : hi), .rdata(v6h_rd)
  );
  sist_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_v6l (
    .clk, .we(clr || (cmd.wr && v6)), .addr(ram_addr),
    .wdata(clr ? 64'd0 : lo), .rdata(v6l_rd)
  );

  assign sts.clr_done = clr_done;
  assign sts.active   = act;
  assign sts.hlast    = (hk == 3'd7);
  assign sts.match    = v6 ? (v6h_rd == hi && v6l_rd == lo) : (v4_rd == hi[63:32]);
  assign sts.empty    = v6 ? (v6h_rd == '0 && v6l_rd == '0) : (v4_rd == '0);
  assign sts.last     = (ptr == last);
  assign is_v6        = v6 && act;
  assign slot_q       = 8'(ptr);

  // cmd.rd marks cycles whose read data is compared next cycle
  logic rd_q;
  always_ff @(posedge clk) begin
    if (rst) rd_q <= 1'b0;
    else     rd_q <= cmd.rd;
  end

`ifndef ASSERT_OFF
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> rd_q) else $error("write without a prior probe read");
  a_no_clr_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> clr_done) else $error("item loaded during clearing");
  a_clr_stays: assert property (@(posedge clk) disable iff (rst)
    $past(clr_done) |-> clr_done) else $error("clear flag dropped");
`endif
endmodule

// ===== rtl/sist_ctrl.sv =====
// Controller: clearing sweep, probe sequencing and output handshake.
module sist_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          outcome,
  output logic                res_v6,
  output logic [7:0]          slot,
  output logic [11:0]         vlan_id,
  input  logic                dp_v6,
  input  logic [7:0]          dp_slot,
  input  logic [11:0]         dp_vlan,
  output sist_pkg::sist_cmd_t cmd,
  input  sist_pkg::sist_sts_t sts
);
  import sist_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_QUO   = 3'd3;
  localparam logic [2:0] S_HOME  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] res, res_next;
  logic       take, free;

  // Result register frees when empty or being taken
  assign free     = !out_valid || !out_stall;
  assign in_stall = !(state == S_IDLE);
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    res_next   = res;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = !sts.clr_done;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (!sts.active) begin
          res_next   = OUT_IGNORED;
          state_next = S_DONE;
        end else begin
          cmd.hstep = 1'b1;
          if (sts.hlast) state_next = S_QUO;
        end
      end
      S_QUO: begin
        cmd.quo    = 1'b1;
        state_next = S_HOME;
      end
      S_HOME: begin
        cmd.home   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.match) begin
          res_next   = OUT_KNOWN;
          state_next = S_DONE;
        end else if (sts.empty) begin
          cmd.wr     = 1'b1;
          res_next   = OUT_INSERTED;
          state_next = S_DONE;
        end else if (sts.last) begin
          res_next   = OUT_FULL;
          state_next = S_DONE;
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && free) out_valid <= 1'b1;
      else if (!out_stall)         out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (state == S_DONE && free) begin
      outcome <= res;
      res_v6  <= (res == OUT_IGNORED) ? 1'b0 : dp_v6;
      slot    <= (res == OUT_IGNORED || res == OUT_FULL) ? 8'd0 : dp_slot;
      vlan_id <= dp_vlan;
    end
  end

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(outcome) && $stable(slot))
    else $error("result changed under stall");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    take |=> state == S_HASH) else $error("item taken outside idle");
  a_wr_insert: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |=> state == S_DONE && res == OUT_INSERTED)
    else $error("write without insert result");
`endif
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the source address seen table.
module tb;
  import sist_pkg::*;

  localparam int DEPTH = 256;
  localparam int V4_POOL = 64;
  localparam int V6_POOL = 48;

  typedef struct {
    logic [15:0] outer_type;
    logic [15:0] tag_control;
    logic [15:0] inner_type;
    logic [7:0]  version_byte;
    logic [63:0] src_high;
    logic [63:0] src_low;
    bit          drain_first; // hold this item until every result is back
  } frame_t;

  typedef struct {
    logic [1:0]  outcome;
    logic        is_v6;
    logic [7:0]  slot;
    logic [11:0] vlan_id;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] outer_type = '0;
  logic [15:0] tag_control = '0;
  logic [15:0] inner_type = '0;
  logic [7:0]  version_byte = '0;
  logic [63:0] src_high = '0;
  logic [63:0] src_low = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0]  outcome;
  logic        is_v6;
  logic [7:0]  slot;
  logic [11:0] vlan_id;

  source_ip_seen_table #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .outer_type(outer_type), .tag_control(tag_control), .inner_type(inner_type),
    .version_byte(version_byte), .src_high(src_high), .src_low(src_low),
    .out_valid(out_valid), .out_stall(out_stall),
    .outcome(outcome), .is_v6(is_v6), .slot(slot), .vlan_id(vlan_id)
  );

  always #10 clk = ~clk;

  // Shadow copies of the two address tables.
  logic [31:0] v4_shadow [DEPTH];
  logic [63:0] v6_shadow_high [DEPTH];
  logic [63:0] v6_shadow_low [DEPTH];

  frame_t   pending_frames[$];
  verdict_t awaited_verdicts[$];
  int       error_count = 0;
  int       frames_taken = 0;

  logic [31:0] v4_pool [V4_POOL];
  logic [63:0] v6_pool_high [V6_POOL];
  logic [63:0] v6_pool_low [V6_POOL];

  function automatic int v6_wt(input int k);
    int w [16] = '{1, 2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};
    return w[k];
  endfunction

  // Classify one frame and update the shadow tables the way the block does.
  function automatic verdict_t classify_frame(input frame_t f);
    verdict_t    v;
    logic [15:0] ethertype;
    bit          v4, v6;
    int          home, idx, n, sum;
    logic [31:0] a4;
    bit          hit, vacant;
    v.outcome = OUT_IGNORED;
    v.is_v6 = 1'b0;
    v.slot = '0;
    v.vlan_id = '0;
    ethertype = f.outer_type;
    if (f.outer_type == TYPE_VLAN) begin
      v.vlan_id = f.tag_control[11:0] & VLAN_MASK;
      ethertype = f.inner_type;
    end
    v4 = (ethertype == TYPE_IPV4) && (f.version_byte == VER_IPV4);
    v6 = !v4 && (ethertype == TYPE_IPV6) && (f.version_byte == VER_IPV6);
    if (!(v4 || v6)) return v;
    a4 = f.src_high[63:32];
    v.is_v6 = v6;
    sum = 0;
    if (v4) begin
      sum = a4[31:24] + 2 * a4[23:16] + 3 * a4[15:8] + 5 * a4[7:0];
    end else begin
      for (int k = 0; k < 8; k++) begin
        sum += v6_wt(k) * f.src_high[63 - 8 * k -: 8];
        sum += v6_wt(k + 8) * f.src_low[63 - 8 * k -: 8];
      end
    end
    home = sum % DEPTH;
    v.outcome = OUT_FULL;
    for (n = 0; n < DEPTH; n++) begin
      idx = (home + n) % DEPTH;
      if (v4) begin
        hit = (v4_shadow[idx] == a4);
        vacant = (v4_shadow[idx] == '0);
      end else begin
        hit = (v6_shadow_high[idx] == f.src_high) && (v6_shadow_low[idx] == f.src_low);
        vacant = (v6_shadow_high[idx] == '0) && (v6_shadow_low[idx] == '0);
      end
      if (hit) begin
        v.outcome = OUT_KNOWN;
        v.slot = idx[7:0];
        return v;
      end
      if (vacant) begin
        if (v4) v4_shadow[idx] = a4;
        else begin
          v6_shadow_high[idx] = f.src_high;
          v6_shadow_low[idx] = f.src_low;
        end
        v.outcome = OUT_INSERTED;
        v.slot = idx[7:0];
        return v;
      end
    end
    return v;
  endfunction

  function automatic frame_t mk(input logic [15:0] ot, input logic [15:0] tc,
                                input logic [15:0] it, input logic [7:0] vb,
                                input logic [63:0] hi, input logic [63:0] lo);
    frame_t f;
    f.outer_type = ot;
    f.tag_control = tc;
    f.inner_type = it;
    f.version_byte = vb;
    f.src_high = hi;
    f.src_low = lo;
    f.drain_first = 1'b0;
    return f;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Wrap an address in an untagged or tagged header with random filler.
  function automatic frame_t wrap_ip(input bit as_v6, input logic [63:0] hi,
                                     input logic [63:0] lo);
    logic [15:0] t;
    bit          with_tag;
    t = as_v6 ? TYPE_IPV6 : TYPE_IPV4;
    with_tag = 1'($urandom_range(0, 1));
    if (with_tag)
      return mk(TYPE_VLAN, 16'($urandom), t, as_v6 ? VER_IPV6 : VER_IPV4, hi, lo);
    return mk(t, 16'($urandom), 16'($urandom), as_v6 ? VER_IPV6 : VER_IPV4, hi, lo);
  endfunction

  // Noise and broken headers: right type with a wrong version, or garbage.
  function automatic frame_t junk_frame();
    frame_t f;
    f = mk(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), rand64(), rand64());
    case ($urandom_range(0, 3))
      0: f.outer_type = TYPE_IPV4;
      1: f.outer_type = TYPE_IPV6;
      2: begin
        f.outer_type = TYPE_VLAN;
        f.inner_type = $urandom_range(0, 1) ? TYPE_IPV4 : TYPE_IPV6;
      end
      default: ;
    endcase
    return f;
  endfunction

  // Driver: offer pending items in bursts with random gaps between them.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    bit     offer;
    frame_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && !in_stall) begin
        nxt = mk(outer_type, tag_control, inner_type, version_byte, src_high, src_low);
        awaited_verdicts.push_back(classify_frame(nxt));
        frames_taken++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_frames.size() > 0 &&
                     !(pending_frames[0].drain_first && awaited_verdicts.size() > 0)) begin
          nxt = pending_frames.pop_front();
          outer_type <= nxt.outer_type;
          tag_control <= nxt.tag_control;
          inner_type <= nxt.inner_type;
          version_byte <= nxt.version_byte;
          src_high <= nxt.src_high;
          src_low <= nxt.src_low;
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 30) : 0;
          end
        end
      end
      in_valid <= offer;
    end
  end

  // Receiver: stall on a changing pattern, with one long hold-off early on.
  int rx_cycle = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (!held_once && frames_taken >= 60) begin
        held_once = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case ((rx_cycle / 97) % 4)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= (rx_cycle % 5) < 2;
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_verdicts.size() == 0) begin
        $error("result with no item waiting: outcome %0d slot %0d", outcome, slot);
        error_count++;
      end else begin
        want = awaited_verdicts.pop_front();
        if (outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, outcome);
          error_count++;
        end
        if (is_v6 !== want.is_v6) begin
          $error("is_v6: expected %0d, got %0d", want.is_v6, is_v6);
          error_count++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot);
          error_count++;
        end
        if (vlan_id !== want.vlan_id) begin
          $error("vlan_id: expected %0h, got %0h", want.vlan_id, vlan_id);
          error_count++;
        end
      end
    end
  end

  initial begin
    frame_t f;
    int     pick;
    for (int k = 0; k < DEPTH; k++) begin
      v4_shadow[k] = '0;
      v6_shadow_high[k] = '0;
      v6_shadow_low[k] = '0;
    end
    for (int k = 0; k < V4_POOL; k++) v4_pool[k] = $urandom | 32'h1;
    for (int k = 0; k < V6_POOL; k++) begin
      v6_pool_high[k] = rand64();
      v6_pool_low[k] = rand64() | 64'h1;
    end

    // Directed: address extremes, zero addresses, tags, near misses.
    pending_frames.push_back(mk(TYPE_IPV4, 16'h0000, 16'h0000, VER_IPV4,
                                64'h0000_0001_0000_0000, '0));
    pending_frames.push_back(mk(TYPE_IPV4, 16'hffff, 16'hffff, VER_IPV4,
                                64'hffff_ffff_ffff_ffff, '1));
    pending_frames.push_back(mk(TYPE_IPV4, 16'h0000, 16'h0000, VER_IPV4, '0, '1));
    pending_frames.push_back(mk(TYPE_VLAN, 16'hffff, TYPE_IPV4, VER_IPV4,
                                64'h0a00_0001_dead_beef, '0));
    pending_frames.push_back(mk(TYPE_VLAN, 16'hf000, TYPE_IPV4, VER_IPV4,
                                64'h0a00_0001_0000_0000, '1));
    pending_frames.push_back(mk(TYPE_IPV6, 16'h0000, 16'h0000, VER_IPV6, '1, '1));
    pending_frames.push_back(mk(TYPE_VLAN, 16'h0abc, TYPE_IPV6, VER_IPV6,
                                64'h2001_0db8_0000_0000, 64'h1));
    pending_frames.push_back(mk(TYPE_IPV6, 16'h0000, 16'h0000, VER_IPV6, '0, '0));
    pending_frames.push_back(mk(TYPE_IPV6, 16'h0000, 16'h0000, VER_IPV6, '0, 64'h1));
    pending_frames.push_back(mk(TYPE_IPV6, 16'h0000, 16'h0000, VER_IPV6, '1, '1));
    pending_frames.push_back(mk(TYPE_IPV4, 16'h0000, 16'h0000, VER_IPV6,
                                64'h0102_0304_0000_0000, '0));
    pending_frames.push_back(mk(TYPE_IPV6, 16'h0000, 16'h0000, VER_IPV4, '1, '1));
    pending_frames.push_back(mk(TYPE_VLAN, 16'h0123, TYPE_VLAN, VER_IPV4, '1, '1));
    pending_frames.push_back(mk(TYPE_VLAN, 16'h0fff, 16'hffff, 8'hff, '1, '1));
    pending_frames.push_back(mk(TYPE_IPV6, 16'hffff, TYPE_IPV4, VER_IPV4, '1, '1));
    pending_frames.push_back(mk(16'hffff, 16'hffff, TYPE_IPV4, VER_IPV4, '1, '1));
    pending_frames.push_back(mk(16'h0000, 16'h0000, 16'h0000, 8'h00, '0, '0));
    f = mk(TYPE_VLAN, 16'h5a5a, TYPE_IPV4, VER_IPV4, 64'hffff_ffff_0000_0000, '0);
    f.drain_first = 1'b1;
    pending_frames.push_back(f);

    // Random: mostly well-formed frames from small address pools, so
    // repeats and probe collisions are common, plus some noise.
    for (int n = 0; n < 950; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        f = wrap_ip(1'b0, {v4_pool[$urandom_range(0, V4_POOL - 1)], $urandom}, rand64());
      end else if (pick < 7) begin
        pick = $urandom_range(0, V6_POOL - 1);
        f = wrap_ip(1'b1, v6_pool_high[pick], v6_pool_low[pick]);
      end else if (pick < 8) begin
        f = wrap_ip(1'($urandom_range(0, 1)), rand64(), rand64());
      end else begin
        f = junk_frame();
      end
      pending_frames.push_back(f);
    end

    // Fill the IPv4 table past capacity, then probe the full table.
    for (int n = 0; n < 330; n++) begin
      f = wrap_ip(1'b0, {16'(n + 1), 16'($urandom), $urandom}, rand64());
      f.drain_first = (n == 0);
      pending_frames.push_back(f);
    end
    for (int n = 0; n < 20; n++) begin
      case (n % 4)
        0: f = wrap_ip(1'b0, {v4_pool[$urandom_range(0, V4_POOL - 1)], $urandom}, '0);
        1: f = wrap_ip(1'b0, {$urandom, $urandom}, '1);
        2: f = wrap_ip(1'b0, {32'h0, $urandom}, rand64());
        default: f = junk_frame();
      endcase
      pending_frames.push_back(f);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (pending_frames.size() == 0 && !in_valid);
    wait (awaited_verdicts.size() == 0);
    repeat (2 * DEPTH + 20) @(posedge clk);
    if (error_count == 0 && awaited_verdicts.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(64'd3000000 * 20);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
